>>> design/mist_pkg.sv
// mist_pkg: shared constants, opcodes, state and status types for the meter id slot table
// depends on: nothing
`timescale 1ns / 1ps
`default_nettype none
package mist_pkg;

   // default table depth
   localparam int ENTRIES_DEF = 128;

   // field widths
   localparam int OP_W    = 3;
   localparam int ID_W    = 32;
   localparam int IDX_W   = 7;
   localparam int SLOT_W  = 8;
   localparam int COUNT_W = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // opcodes
   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
   localparam logic [OP_W-1:0] OP_READ   = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ
   } state_type;

   // report from the scan unit
   typedef struct packed {
      logic              done;
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } scan_status_type;

endpackage
`default_nettype wire

>>> design/mist_ram.sv
// mist_ram: generic single write port, single read port ram with registered read data
// depends on: nothing
`timescale 1ns / 1ps
`default_nettype none
module mist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> design/mist_scan.sv
// mist_scan: slot scan unit, one address counter and one 32-bit comparator shared by insert and find
// depends on: mist_pkg; reads the id ram through the top level
`timescale 1ns / 1ps
`default_nettype none
module mist_scan #(
   parameter int ENTRIES = mist_pkg::ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [mist_pkg::ID_W-1:0]     key,
   output logic [$clog2(ENTRIES)-1:0]    raddr,
   input  logic [mist_pkg::ID_W-1:0]     rdata,
   input  logic                          rvalid,
   output mist_pkg::scan_status_type     status
);
   import mist_pkg::*;

   localparam int AW = $clog2(ENTRIES);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);
   localparam logic [SLOT_W-1:0] NONE_SLOT = SLOT_W'(ENTRIES);

   logic              run_ff, run_in;
   logic              chk_ff, chk_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic [SLOT_W-1:0] chk_slot_ff, chk_slot_in;
   logic [ID_W-1:0]   key_ff, key_in;
   logic [ID_W-1:0]   data_eff;
   logic              match;
   logic              at_last;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         chk_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         chk_ff <= chk_in;
      end
   end

   // address and key registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      chk_slot_ff <= chk_slot_in;
      key_ff      <= key_in;
   end

   // compare the word read last cycle; an entry never written reads as empty
   always_comb begin
      data_eff      = rvalid ? rdata : '0;
      match         = chk_ff && (data_eff == key_ff);
      at_last       = chk_ff && (chk_slot_ff == LAST_SLOT);
      status.done   = match || at_last;
      status.hit    = match;
      status.slot   = match ? chk_slot_ff : NONE_SLOT;
   end

   assign raddr = cnt_ff[AW-1:0];

   // read one slot per cycle, compare it the next
   always_comb begin
      run_in      = run_ff;
      chk_in      = run_ff;
      cnt_in      = cnt_ff;
      chk_slot_in = cnt_ff;
      key_in      = key_ff;
      if (run_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_SLOT) begin
            run_in = 1'b0;
         end
      end
      if (status.done) begin
         run_in = 1'b0;
         chk_in = 1'b0;
      end
      if (go) begin
         run_in = 1'b1;
         chk_in = 1'b0;
         cnt_in = '0;
         key_in = key;
      end
   end

endmodule
`default_nettype wire

>>> design/meter_id_slot_table.sv
// meter_id_slot_table: top level, sequencer, slot valid bits, occupancy count, result word register
// depends on: mist_pkg, mist_ram, mist_scan
//
//   channel   ports                                         handshake
//   request   req_opcode, req_meter_id, req_slot_index      start && !busy
//   response  rsp_result_slot, rsp_result_id, rsp_failed,   rsp_strobe, one cycle
//             rsp_occupied_count
//
// insert and find scan the slots through one comparator, one slot per cycle, each slot
// compared after its registered ram read and the result word registered after that.
// read waits in ST_READ on the registered ram read; remove, clear and unused opcodes skip it.
// busy is high while a scan or read is in flight; a new word may be accepted in the
// cycle its predecessor's result is strobed.
// reset clears the slot valid bits and count at once, so every slot reads as empty;
// clear does the same. the receiver cannot stall the response.
`timescale 1ns / 1ps
`default_nettype none
module meter_id_slot_table #(
   parameter int ENTRIES = mist_pkg::ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [mist_pkg::OP_W-1:0]    req_opcode,
   input  logic [mist_pkg::ID_W-1:0]    req_meter_id,
   input  logic [mist_pkg::IDX_W-1:0]   req_slot_index,
   output logic                         rsp_strobe,
   output logic [mist_pkg::SLOT_W-1:0]  rsp_result_slot,
   output logic [mist_pkg::ID_W-1:0]    rsp_result_id,
   output logic                         rsp_failed,
   output logic [mist_pkg::COUNT_W-1:0] rsp_occupied_count
);
   import mist_pkg::*;

   localparam int AW = $clog2(ENTRIES);
   localparam logic [SLOT_W-1:0] ENTRIES_SLOT = SLOT_W'(ENTRIES);

   state_type            state_ff, state_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic                 read_ok_ff, read_ok_in;
   logic                 vld_rd_ff, vld_rd_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic                 rsp_failed_ff, rsp_failed_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [SLOT_W-1:0]    idx_ext;
   logic                 idx_ok;
   logic [AW-1:0]        idx_addr;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [AW-1:0]        ram_raddr;
   logic [ID_W-1:0]      ram_rdata;

   logic                 scan_go;
   logic [ID_W-1:0]      scan_key;
   logic [AW-1:0]        scan_raddr;
   scan_status_type      scan_status;

   // id storage
   mist_ram #(
      .WIDTH (ID_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (id_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // shared scan comparator
   mist_scan #(
      .ENTRIES (ENTRIES)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .go     (scan_go),
      .key    (scan_key),
      .raddr  (scan_raddr),
      .rdata  (ram_rdata),
      .rvalid (vld_rd_ff),
      .status (scan_status)
   );

   // slot index decode
   assign idx_ext  = {1'b0, req_slot_index};
   assign idx_ok   = idx_ext < ENTRIES_SLOT;
   assign idx_addr = idx_ext[AW-1:0];

   // ram read address and matching valid bit
   assign ram_raddr = (state_ff == ST_SCAN) ? scan_raddr : idx_addr;
   assign vld_rd_in = (SLOT_W'(ram_raddr) < ENTRIES_SLOT) ? valid_ff[ram_raddr] : 1'b0;
   assign ram_waddr = scan_status.slot[AW-1:0];
   assign scan_key  = (req_opcode == OP_INSERT) ? '0 : req_meter_id;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      read_ok_ff    <= read_ok_in;
      vld_rd_ff     <= vld_rd_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_failed_ff <= rsp_failed_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // sequencer: next state, table updates and result word
   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      read_ok_in    = read_ok_ff;
      rsp_strobe_in = 1'b0;
      rsp_slot_in   = rsp_slot_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_failed_in = rsp_failed_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      scan_go       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in         = req_opcode;
               id_in         = req_meter_id;
               read_ok_in    = idx_ok;
               rsp_slot_in   = '0;
               rsp_id_in     = '0;
               rsp_failed_in = 1'b0;
               case (req_opcode)
                  OP_INSERT, OP_FIND: begin
                     scan_go  = 1'b1;
                     state_in = ST_SCAN;
                  end
                  OP_READ: begin
                     state_in = ST_READ;
                  end
                  OP_REMOVE: begin
                     if (idx_ok) begin
                        valid_in[idx_addr] = 1'b0;
                        if (count_ff != '0) begin
                           count_in = count_ff - 1'b1;
                        end
                     end
                     rsp_strobe_in = 1'b1;
                  end
                  OP_CLEAR: begin
                     valid_in      = '0;
                     count_in      = '0;
                     rsp_strobe_in = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_status.done) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_slot_in   = scan_status.slot;
               rsp_id_in     = '0;
               rsp_failed_in = !scan_status.hit;
               // insert: claim the first empty slot
               if (op_ff == OP_INSERT && scan_status.hit) begin
                  ram_we              = 1'b1;
                  valid_in[ram_waddr] = 1'b1;
                  if (count_ff != COUNT_MAX) begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end
         end
         ST_READ: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_slot_in   = '0;
            rsp_id_in     = (read_ok_ff && vld_rd_ff) ? ram_rdata : '0;
            rsp_failed_in = 1'b0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (rsp_strobe_in) begin
         rsp_count_in = count_in;
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_result_slot    = rsp_slot_ff;
   assign rsp_result_id      = rsp_id_ff;
   assign rsp_failed         = rsp_failed_ff;
   assign rsp_occupied_count = rsp_count_ff;

   // every result word finishes its operation
   a_strobe_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobed while an operation is still running");

   // remove, clear and unused opcodes answer in the next cycle
   a_short_op_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode != OP_INSERT && req_opcode != OP_FIND &&
       req_opcode != OP_READ) |=> rsp_strobe)
      else $error("remove, clear or unused opcode did not answer in one cycle");

   // a failure always reports the out-of-range slot
   a_fail_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_failed) |-> (rsp_result_slot == ENTRIES_SLOT))
      else $error("failed result without the out-of-range slot");

   // the scan unit only finishes while the sequencer waits on it
   a_scan_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_status.done |-> (state_ff == ST_SCAN))
      else $error("scan finished outside of a scan");

endmodule
`default_nettype wire
